### rtl/aafs_pkg.sv
// ----------------------------------------------------------------------------
// aafs_pkg
// Shared types and constants of the area average fit scaler
// ----------------------------------------------------------------------------
package aafs_pkg;

   localparam int MAX_SOURCE_DIM = 1024;
   localparam int MAX_PANEL_DIM  = 256;
   localparam int SRC_IDX_W      = $clog2(MAX_SOURCE_DIM);
   localparam int SRC_DIM_W      = SRC_IDX_W + 1;
   localparam int PAN_DIM_W      = $clog2(MAX_PANEL_DIM) + 1;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = SRC_DIM_W;
   localparam int GRID_W         = 20;
   localparam int COL_W          = 8;
   localparam int SUM_W          = 28;
   localparam int CNT_W          = 21;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 3'd0,
      CSR_SOURCE_HEIGHT = 3'd1,
      CSR_PANEL_WIDTH   = 3'd2,
      CSR_PANEL_HEIGHT  = 3'd3,
      CSR_FIT_CHOICE    = 3'd4
   } csr_index_type;

   localparam logic [1:0] FIT_STRETCH   = 2'd0;
   localparam logic [1:0] FIT_CROP      = 2'd1;
   localparam logic [1:0] FIT_LETTERBOX = 2'd2;
   // spare fit code, handled as letterbox
   localparam logic [1:0] FIT_SPARE     = 2'd3;

   typedef enum logic [1:0] {
      DIV_DIM,
      DIV_COL,
      DIV_ROW
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LATCH,
      ST_PROD,
      ST_DIM_GO,
      ST_DIM,
      ST_COL_GO,
      ST_COL,
      ST_ROW_GO,
      ST_ROW,
      ST_INIT,
      ST_READ,
      ST_ACC,
      ST_AVG,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic        take_pixel;
      logic        latch_cfg;
      logic        calc_prod;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_dim;
      logic        take_col;
      logic        take_row;
      logic        init_frame;
      logic        mem_read;
      logic        accumulate;
      logic        avg_start;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic emit;
      logic div_busy;
      logic avg_busy;
      logic out_free;
   } status_type;

endpackage

### rtl/aafs_if.sv
// ----------------------------------------------------------------------------
// aafs_if
// Pixel request and result channels of the area average fit scaler
// ----------------------------------------------------------------------------
interface aafs_req_if;
   logic       valid;
   logic       ready;
   logic       frame_start;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, frame_start, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, frame_start, red_in, green_in, blue_in, output ready);
endinterface

interface aafs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_x;
   logic [7:0] out_y;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;

   modport source (output valid, out_x, out_y, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, out_x, out_y, red_out, green_out, blue_out, output ready);
endinterface

### rtl/aafs_ctrl.sv
// ----------------------------------------------------------------------------
// aafs_ctrl
// Sequencer: frame setup, per-word accumulate and cell averaging
// ----------------------------------------------------------------------------
module aafs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_frame_start,
   output logic                  req_ready,
   input  aafs_pkg::status_type  status,
   output aafs_pkg::cmd_type     cmd,
   output aafs_pkg::state_type   state
);

   aafs_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aafs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.div_sel = aafs_pkg::DIV_DIM;
      unique case (state_ff)
         aafs_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.take_pixel = req_valid;
            if (req_valid) begin
               if (req_frame_start) begin
                  state_in = aafs_pkg::ST_LATCH;
               end else if (status.active) begin
                  state_in = aafs_pkg::ST_READ;
               end
            end
         end
         aafs_pkg::ST_LATCH: begin
            cmd.latch_cfg = 1'b1;
            state_in      = aafs_pkg::ST_PROD;
         end
         aafs_pkg::ST_PROD: begin
            cmd.calc_prod = 1'b1;
            state_in      = aafs_pkg::ST_DIM_GO;
         end
         aafs_pkg::ST_DIM_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = aafs_pkg::DIV_DIM;
            state_in      = aafs_pkg::ST_DIM;
         end
         aafs_pkg::ST_DIM: begin
            if (!status.div_busy) begin
               cmd.take_dim = 1'b1;
               state_in     = aafs_pkg::ST_COL_GO;
            end
         end
         aafs_pkg::ST_COL_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = aafs_pkg::DIV_COL;
            state_in      = aafs_pkg::ST_COL;
         end
         aafs_pkg::ST_COL: begin
            if (!status.div_busy) begin
               cmd.take_col = 1'b1;
               state_in     = aafs_pkg::ST_ROW_GO;
            end
         end
         aafs_pkg::ST_ROW_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = aafs_pkg::DIV_ROW;
            state_in      = aafs_pkg::ST_ROW;
         end
         aafs_pkg::ST_ROW: begin
            if (!status.div_busy) begin
               cmd.take_row = 1'b1;
               state_in     = aafs_pkg::ST_INIT;
            end
         end
         aafs_pkg::ST_INIT: begin
            cmd.init_frame = 1'b1;
            state_in       = aafs_pkg::ST_READ;
         end
         aafs_pkg::ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = aafs_pkg::ST_ACC;
         end
         aafs_pkg::ST_ACC: begin
            cmd.accumulate = 1'b1;
            if (status.emit) begin
               cmd.avg_start = 1'b1;
               state_in      = aafs_pkg::ST_AVG;
            end else begin
               state_in = aafs_pkg::ST_IDLE;
            end
         end
         aafs_pkg::ST_AVG: begin
            if (!status.avg_busy) begin
               state_in = aafs_pkg::ST_LOAD;
            end
         end
         aafs_pkg::ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = aafs_pkg::ST_IDLE;
            end
         end
         default: state_in = aafs_pkg::ST_IDLE;
      endcase
   end

   assign state = state_ff;

endmodule

### rtl/aafs_dp.sv
// ----------------------------------------------------------------------------
// aafs_dp
// Datapath: registers, grid setup divider, column store, cell average divider
// ----------------------------------------------------------------------------
module aafs_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [aafs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [aafs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [7:0]                           pix_red,
   input  logic [7:0]                           pix_green,
   input  logic [7:0]                           pix_blue,
   input  aafs_pkg::cmd_type                    cmd,
   output aafs_pkg::status_type                 status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [7:0]                           rsp_x,
   output logic [7:0]                           rsp_y,
   output logic [7:0]                           rsp_red,
   output logic [7:0]                           rsp_green,
   output logic [7:0]                           rsp_blue
);

   localparam int SW = aafs_pkg::SRC_DIM_W;
   localparam int PW = aafs_pkg::PAN_DIM_W;
   localparam int GW = aafs_pkg::GRID_W;
   localparam int IW = aafs_pkg::SRC_IDX_W;
   localparam int OW = GW + 1;
   localparam int SM = aafs_pkg::SUM_W;
   localparam int CN = aafs_pkg::CNT_W;
   localparam int CW = aafs_pkg::COL_W;
   localparam int DEPTH = aafs_pkg::MAX_SOURCE_DIM;

   typedef struct packed {
      logic [SM-1:0] red;
      logic [SM-1:0] green;
      logic [SM-1:0] blue;
      logic [CN-1:0] count;
   } acc_entry_type;

   function automatic logic [SW-1:0] clamp_src(input logic [SW-1:0] v);
      if (v == '0) return SW'(1);
      if (v > SW'(aafs_pkg::MAX_SOURCE_DIM)) return SW'(aafs_pkg::MAX_SOURCE_DIM);
      return v;
   endfunction

   function automatic logic [PW-1:0] clamp_pan(input logic [PW-1:0] v);
      if (v == '0) return PW'(1);
      if (v > PW'(aafs_pkg::MAX_PANEL_DIM)) return PW'(aafs_pkg::MAX_PANEL_DIM);
      return v;
   endfunction

   // configuration registers
   logic [SW-1:0] sw_cfg_ff, sh_cfg_ff;
   logic [PW-1:0] tw_cfg_ff, th_cfg_ff;
   logic [1:0]    fit_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_cfg_ff  <= SW'(64);
         sh_cfg_ff  <= SW'(32);
         tw_cfg_ff  <= PW'(64);
         th_cfg_ff  <= PW'(32);
         fit_cfg_ff <= aafs_pkg::FIT_LETTERBOX;
      end else if (csr_we) begin
         unique case (csr_index)
            aafs_pkg::CSR_SOURCE_WIDTH:  sw_cfg_ff  <= csr_wdata;
            aafs_pkg::CSR_SOURCE_HEIGHT: sh_cfg_ff  <= csr_wdata;
            aafs_pkg::CSR_PANEL_WIDTH:   tw_cfg_ff  <= csr_wdata[PW-1:0];
            aafs_pkg::CSR_PANEL_HEIGHT:  th_cfg_ff  <= csr_wdata[PW-1:0];
            aafs_pkg::CSR_FIT_CHOICE:    fit_cfg_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // frame sizes latched at frame start
   logic [SW-1:0] fsw_ff, fsh_ff;
   logic [PW-1:0] ftw_ff, fth_ff;
   logic [1:0]    fit_ff;
   logic [GW-1:0] p1_ff, p2_ff;
   logic          horiz_ff;
   logic [GW-1:0] p1_in, p2_in;

   assign p1_in = GW'(ftw_ff) * GW'(fsh_ff);
   assign p2_in = GW'(fth_ff) * GW'(fsw_ff);

   always_ff @(posedge clock) begin
      if (cmd.latch_cfg) begin
         fsw_ff <= clamp_src(sw_cfg_ff);
         fsh_ff <= clamp_src(sh_cfg_ff);
         ftw_ff <= clamp_pan(tw_cfg_ff);
         fth_ff <= clamp_pan(th_cfg_ff);
         fit_ff <= (fit_cfg_ff == aafs_pkg::FIT_SPARE) ? aafs_pkg::FIT_LETTERBOX
                                                       : fit_cfg_ff;
      end
      if (cmd.calc_prod) begin
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         horiz_ff <= (fit_ff == aafs_pkg::FIT_CROP) ? (p1_in >= p2_in) : (p1_in <= p2_in);
      end
   end

   // scaled grid and its per-step increments
   logic [GW-1:0] w_ff, h_ff, wq_ff, hq_ff;
   logic [SW-1:0] wr_ff, hr_ff;
   logic [GW-1:0] q_min1;

   // shared restoring divider for grid setup, one quotient bit a cycle
   logic [GW-1:0]        dvd_ff;
   logic [SW-1:0]        rem_ff, dvs_ff;
   logic [4:0]           dcnt_ff;
   logic                 dbusy_ff;
   logic [SW:0]          rem_t;
   logic                 rem_ge;

   assign rem_t  = {rem_ff, dvd_ff[GW-1]};
   assign rem_ge = rem_t >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff && dcnt_ff == 5'd1) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff  <= '0;
         dcnt_ff <= 5'(GW);
         case (cmd.div_sel)
            aafs_pkg::DIV_COL: begin
               dvd_ff <= w_ff;
               dvs_ff <= fsw_ff;
            end
            aafs_pkg::DIV_ROW: begin
               dvd_ff <= h_ff;
               dvs_ff <= fsh_ff;
            end
            default: begin
               dvd_ff <= horiz_ff ? p1_ff : p2_ff;
               dvs_ff <= horiz_ff ? fsw_ff : fsh_ff;
            end
         endcase
      end else if (dbusy_ff) begin
         rem_ff  <= rem_ge ? SW'(rem_t - {1'b0, dvs_ff}) : rem_t[SW-1:0];
         dvd_ff  <= {dvd_ff[GW-2:0], rem_ge};
         dcnt_ff <= dcnt_ff - 5'd1;
      end
   end

   assign q_min1 = (dvd_ff == '0) ? GW'(1) : dvd_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_dim) begin
         if (fit_ff == aafs_pkg::FIT_STRETCH) begin
            w_ff <= GW'(ftw_ff);
            h_ff <= GW'(fth_ff);
         end else if (horiz_ff) begin
            w_ff <= GW'(ftw_ff);
            h_ff <= (fit_ff == aafs_pkg::FIT_CROP) ? dvd_ff : q_min1;
         end else begin
            w_ff <= (fit_ff == aafs_pkg::FIT_CROP) ? dvd_ff : q_min1;
            h_ff <= GW'(fth_ff);
         end
      end
      if (cmd.take_col) begin
         wq_ff <= dvd_ff;
         wr_ff <= rem_ff;
      end
      if (cmd.take_row) begin
         hq_ff <= dvd_ff;
         hr_ff <= rem_ff;
      end
   end

   // placement offsets, two's complement
   logic [OW-1:0] dx_pos, dy_pos, dx_neg, dy_neg, offx_in, offy_in;

   assign dx_pos = {1'b0, w_ff} - OW'(ftw_ff);
   assign dy_pos = {1'b0, h_ff} - OW'(fth_ff);
   assign dx_neg = OW'(ftw_ff) - {1'b0, w_ff};
   assign dy_neg = OW'(fth_ff) - {1'b0, h_ff};

   always_comb begin
      case (fit_ff)
         aafs_pkg::FIT_STRETCH: begin
            offx_in = '0;
            offy_in = '0;
         end
         aafs_pkg::FIT_CROP: begin
            offx_in = OW'(0) - (dx_pos >> 1);
            offy_in = OW'(0) - (dy_pos >> 1);
         end
         default: begin
            offx_in = dx_neg >> 1;
            offy_in = dy_neg >> 1;
         end
      endcase
   end

   // raster position and cell tracking: cell = ((p+1)*n-1)/s as quotient and remainder
   logic [OW-1:0] offx_ff, offy_ff;
   logic [GW-1:0] colq_ff, rowq_ff, cq0_ff;
   logic [SW-1:0] colr_ff, rowr_ff, cr0_ff;
   logic [IW-1:0] sx_ff, sy_ff, slot_ff;
   logic          row_first_ff, active_ff;
   logic [GW-1:0] cq0_in, rq0_in;
   logic [SW-1:0] cr0_in, rr0_in;

   assign cq0_in = (wr_ff != '0) ? wq_ff : wq_ff - GW'(1);
   assign cr0_in = (wr_ff != '0) ? wr_ff - SW'(1) : fsw_ff - SW'(1);
   assign rq0_in = (hr_ff != '0) ? hq_ff : hq_ff - GW'(1);
   assign rr0_in = (hr_ff != '0) ? hr_ff - SW'(1) : fsh_ff - SW'(1);

   logic [SW:0]   col_rsum, row_rsum;
   logic          col_ov, row_ov, end_row, end_frame, last_col, last_row;
   logic [GW-1:0] colq_nx, rowq_nx;
   logic [SW-1:0] colr_nx, rowr_nx;

   assign col_rsum  = {1'b0, colr_ff} + {1'b0, wr_ff};
   assign row_rsum  = {1'b0, rowr_ff} + {1'b0, hr_ff};
   assign col_ov    = col_rsum >= {1'b0, fsw_ff};
   assign row_ov    = row_rsum >= {1'b0, fsh_ff};
   assign colr_nx   = col_ov ? SW'(col_rsum - {1'b0, fsw_ff}) : col_rsum[SW-1:0];
   assign rowr_nx   = row_ov ? SW'(row_rsum - {1'b0, fsh_ff}) : row_rsum[SW-1:0];
   assign colq_nx   = colq_ff + wq_ff + GW'(col_ov);
   assign rowq_nx   = rowq_ff + hq_ff + GW'(row_ov);
   assign end_row   = ({1'b0, sx_ff} + SW'(1)) >= fsw_ff;
   assign end_frame = ({1'b0, sy_ff} + SW'(1)) >= fsh_ff;
   assign last_col  = end_row || (wq_ff != '0) || col_ov;
   assign last_row  = end_frame || (hq_ff != '0) || row_ov;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (cmd.init_frame) begin
         active_ff <= 1'b1;
      end else if (cmd.accumulate && end_row && end_frame) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_frame) begin
         offx_ff      <= offx_in;
         offy_ff      <= offy_in;
         cq0_ff       <= cq0_in;
         cr0_ff       <= cr0_in;
         colq_ff      <= cq0_in;
         colr_ff      <= cr0_in;
         rowq_ff      <= rq0_in;
         rowr_ff      <= rr0_in;
         sx_ff        <= '0;
         sy_ff        <= '0;
         slot_ff      <= '0;
         row_first_ff <= 1'b1;
      end else if (cmd.accumulate) begin
         if (end_row) begin
            sx_ff   <= '0;
            slot_ff <= '0;
            colq_ff <= cq0_ff;
            colr_ff <= cr0_ff;
            if (!end_frame) begin
               sy_ff        <= sy_ff + IW'(1);
               rowq_ff      <= rowq_nx;
               rowr_ff      <= rowr_nx;
               row_first_ff <= last_row;
            end
         end else begin
            sx_ff   <= sx_ff + IW'(1);
            colq_ff <= colq_nx;
            colr_ff <= colr_nx;
            if (last_col) begin
               slot_ff <= sx_ff + IW'(1);
            end
         end
      end
   end

   // column store, keyed by the first source column of the cell
   acc_entry_type mem [DEPTH];
   acc_entry_type rdata_ff, base, upd;
   logic [7:0]    red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_pixel) begin
         red_ff   <= pix_red;
         green_ff <= pix_green;
         blue_ff  <= pix_blue;
      end
      if (cmd.mem_read) begin
         rdata_ff <= mem[slot_ff];
      end
      if (cmd.accumulate) begin
         mem[slot_ff] <= upd;
      end
   end

   // first pixel of a cell in the first row of its band starts from zero
   always_comb begin
      base      = (row_first_ff && (sx_ff == slot_ff)) ? '0 : rdata_ff;
      upd.red   = base.red + SM'(red_ff);
      upd.green = base.green + SM'(green_ff);
      upd.blue  = base.blue + SM'(blue_ff);
      upd.count = base.count + CN'(1);
   end

   // target placement and panel bounds
   logic [OW-1:0] tx, ty;
   logic          on_panel;
   logic [CW-1:0] tx_ff, ty_ff;

   assign tx       = {1'b0, colq_ff} + offx_ff;
   assign ty       = {1'b0, rowq_ff} + offy_ff;
   assign on_panel = !tx[OW-1] && !ty[OW-1] && (tx < OW'(ftw_ff)) && (ty < OW'(fth_ff));

   // cell average: eight restoring steps, quotient known below 256
   logic [SM-1:0] ar_ff, ag_ff, ab_ff, dsh_ff;
   logic [CW-1:0] qr_ff, qg_ff, qb_ff;
   logic [2:0]    acnt_ff;
   logic          abusy_ff;
   logic          ge_r, ge_g, ge_b;

   assign ge_r = ar_ff >= dsh_ff;
   assign ge_g = ag_ff >= dsh_ff;
   assign ge_b = ab_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         abusy_ff <= 1'b0;
      end else if (cmd.avg_start) begin
         abusy_ff <= 1'b1;
      end else if (abusy_ff && acnt_ff == '0) begin
         abusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.avg_start) begin
         ar_ff   <= upd.red;
         ag_ff   <= upd.green;
         ab_ff   <= upd.blue;
         dsh_ff  <= SM'(upd.count) << (CW - 1);
         acnt_ff <= 3'(CW - 1);
         tx_ff   <= tx[CW-1:0];
         ty_ff   <= ty[CW-1:0];
      end else if (abusy_ff) begin
         ar_ff   <= ge_r ? ar_ff - dsh_ff : ar_ff;
         ag_ff   <= ge_g ? ag_ff - dsh_ff : ag_ff;
         ab_ff   <= ge_b ? ab_ff - dsh_ff : ab_ff;
         qr_ff   <= {qr_ff[CW-2:0], ge_r};
         qg_ff   <= {qg_ff[CW-2:0], ge_g};
         qb_ff   <= {qb_ff[CW-2:0], ge_b};
         dsh_ff  <= dsh_ff >> 1;
         acnt_ff <= acnt_ff - 3'd1;
      end
   end

   // result output register
   logic          ovalid_ff;
   logic [CW-1:0] ox_ff, oy_ff, or_ff, og_ff, ob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         ox_ff <= tx_ff;
         oy_ff <= ty_ff;
         or_ff <= qr_ff;
         og_ff <= qg_ff;
         ob_ff <= qb_ff;
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_x     = ox_ff;
   assign rsp_y     = oy_ff;
   assign rsp_red   = or_ff;
   assign rsp_green = og_ff;
   assign rsp_blue  = ob_ff;

   // status towards the sequencer
   assign status.active   = active_ff;
   assign status.emit     = last_col && last_row && on_panel;
   assign status.div_busy = dbusy_ff;
   assign status.avg_busy = abusy_ff;
   assign status.out_free = !ovalid_ff || rsp_ready;

endmodule

### rtl/area_average_fit_scaler.sv
// ----------------------------------------------------------------------------
// area_average_fit_scaler
// Box-filter downscaler with stretch, crop and letterbox fit of the panel
// ----------------------------------------------------------------------------
// a word passes through read and accumulate steps; a word that closes a visible cell
// also waits on the 8-step average divider and then for a free output register to load
// a word carrying frame_start first goes through grid setup
// (three waits on the 20-step setup divider plus six control steps)
// reset restores the default registers, no frame active, no store clearing
module area_average_fit_scaler (
   input  logic                                clock,
   input  logic                                reset,
   aafs_req_if.sink                            req_if,
   aafs_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [aafs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [aafs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   aafs_pkg::cmd_type    cmd;
   aafs_pkg::status_type status;
   aafs_pkg::state_type  state;

   // sequencer
   aafs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_frame_start (req_if.frame_start),
      .req_ready       (req_if.ready),
      .status          (status),
      .cmd             (cmd),
      .state           (state)
   );

   // datapath
   aafs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pix_red   (req_if.red_in),
      .pix_green (req_if.green_in),
      .pix_blue  (req_if.blue_in),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_x     (rsp_if.out_x),
      .rsp_y     (rsp_if.out_y),
      .rsp_red   (rsp_if.red_out),
      .rsp_green (rsp_if.green_out),
      .rsp_blue  (rsp_if.blue_out)
   );

   // no word taken while a divider is running
   a_div_blocks: assert property (@(posedge clock) disable iff (reset)
      (status.div_busy || status.avg_busy) |-> !req_if.ready)
      else $error("word accepted during division");

   // a new result only follows an output load
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.load_out))
      else $error("result raised without load");

   // a result is loaded only when the output register can take it
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result overwritten");

   // averaging starts only from the accumulate step
   a_avg_from_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.avg_start |-> (state == aafs_pkg::ST_ACC))
      else $error("average started outside accumulate");

endmodule
